// ===== sv/rct_pkg.sv =====
// ----------------------------------------------------------------------------
// rct_pkg: shared definitions for the resource claim table
// Field widths, operation and status codes, and default sizes.
// ----------------------------------------------------------------------------
package rct_pkg;

   localparam int PIN_COUNT_DEF = 64;
   localparam int BUS_SLOTS_DEF = 4;

   localparam int FUNC_W   = 2;
   localparam int OWNER_W  = 8;
   localparam int PIN_NUM_W = 7;
   localparam int KEY_W    = 64;
   localparam int FREQ_W   = 24;
   localparam int STATUS_W = 2;
   localparam int MASK_W   = 64;
   localparam int MASK_IDX_W = 6;

   localparam logic [FUNC_W-1:0] FUNC_PIN     = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_BUS     = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_INVALID  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_CONFLICT = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOSPACE  = 2'd3;

   typedef logic [OWNER_W-1:0] owner_type;

endpackage

// ===== sv/rct_ram.sv =====
// ----------------------------------------------------------------------------
// rct_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds without rd_en.
// ----------------------------------------------------------------------------
module rct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/resource_claim_table_top.sv =====
// Acquire pin, bus and unknown operations: decided in S_EXEC after accept, then registered.
// One request at a time: a new one is taken only back in S_IDLE, after the last result.
// Release all: sweep states S_SWEEP, S_SWEEP_END, S_FINISH; one owner RAM read per pin.
// Reset clears claim flags, bus slots, mask and rsp_valid at once; no clearing pass.
// ----------------------------------------------------------------------------
// resource_claim_table_top: ownership table for pins and shared buses
// Pin owners live in a RAM with claim flags in flops; bus slots in flops.
// ----------------------------------------------------------------------------
module resource_claim_table_top #(
   parameter int PIN_COUNT = rct_pkg::PIN_COUNT_DEF,
   parameter int BUS_SLOTS = rct_pkg::BUS_SLOTS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [rct_pkg::FUNC_W-1:0]     req_func,
   input  logic [rct_pkg::OWNER_W-1:0]    req_owner_id,
   input  logic [rct_pkg::PIN_NUM_W-1:0]  req_pin,
   input  logic [rct_pkg::KEY_W-1:0]      req_bus_key,
   input  logic [rct_pkg::FREQ_W-1:0]     req_bus_freq,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [rct_pkg::STATUS_W-1:0]   rsp_status,
   input  logic                           csr_wr_en,
   input  logic [rct_pkg::MASK_W-1:0]     csr_wr_data
);

   localparam int PIN_W  = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1;
   localparam int CNT_W  = $clog2(PIN_COUNT + 1);
   localparam int SLOT_W = (BUS_SLOTS > 1) ? $clog2(BUS_SLOTS) : 1;

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_EXEC      = 3'd1;
   localparam logic [2:0] S_SWEEP     = 3'd2;
   localparam logic [2:0] S_SWEEP_END = 3'd3;
   localparam logic [2:0] S_FINISH    = 3'd4;

   logic [2:0]                       state_ff, state_in;
   logic [rct_pkg::MASK_W-1:0]       mask_ff, mask_in;
   logic [rct_pkg::FUNC_W-1:0]       func_ff;
   rct_pkg::owner_type               owner_ff;
   logic [rct_pkg::PIN_NUM_W-1:0]    pin_ff;
   logic [rct_pkg::KEY_W-1:0]        key_ff;
   logic [rct_pkg::FREQ_W-1:0]       freq_ff;
   logic [CNT_W-1:0]                 cnt_ff, cnt_in;
   logic                             chk_vld_ff, chk_vld_in;
   logic [PIN_W-1:0]                 chk_addr_ff, chk_addr_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [rct_pkg::STATUS_W-1:0]     rsp_status_ff, rsp_status_in;

   logic [PIN_COUNT-1:0]             pin_claimed_ff, pin_claimed_in;
   logic [BUS_SLOTS-1:0]             slot_claimed_ff, slot_claimed_in;
   logic [rct_pkg::KEY_W-1:0]        slot_key_ff   [BUS_SLOTS];
   rct_pkg::owner_type               slot_owner_ff [BUS_SLOTS];
   logic [rct_pkg::FREQ_W-1:0]       slot_freq_ff  [BUS_SLOTS];

   logic                             ram_wr_en;
   logic                             ram_rd_en;
   logic [PIN_W-1:0]                 ram_rd_addr;
   rct_pkg::owner_type               ram_rd_data;

   logic                             accept;
   logic                             out_free;
   logic                             emit;
   logic [rct_pkg::STATUS_W-1:0]     emit_status;
   logic [PIN_W-1:0]                 pin_idx;
   logic                             pin_in_range;
   logic                             pin_reserved;
   logic                             pin_held;
   logic                             slot_wr;
   logic                             hit_found;
   logic                             free_found;
   logic [SLOT_W-1:0]                hit_idx;
   logic [SLOT_W-1:0]                free_idx;
   logic [BUS_SLOTS-1:0]             slot_own_vec;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign pin_idx      = pin_ff[PIN_W-1:0];
   assign pin_in_range = (pin_ff < rct_pkg::PIN_NUM_W'(PIN_COUNT));
   assign pin_reserved = mask_ff[pin_ff[rct_pkg::MASK_IDX_W-1:0]];
   assign pin_held     = pin_claimed_ff[pin_idx];

   always_comb begin
      hit_found  = 1'b0;
      free_found = 1'b0;
      hit_idx    = '0;
      free_idx   = '0;
      for (int i = 0; i < BUS_SLOTS; i++) begin
         slot_own_vec[i] = slot_claimed_ff[i] && (slot_owner_ff[i] == owner_ff);
         if (!hit_found && slot_claimed_ff[i] && (slot_key_ff[i] == key_ff)) begin
            hit_found = 1'b1;
            hit_idx   = SLOT_W'(i);
         end
         if (!free_found && !slot_claimed_ff[i]) begin
            free_found = 1'b1;
            free_idx   = SLOT_W'(i);
         end
      end
   end

   always_comb begin
      state_in        = state_ff;
      mask_in         = csr_wr_en ? csr_wr_data : mask_ff;
      cnt_in          = cnt_ff;
      chk_vld_in      = 1'b0;
      chk_addr_in     = chk_addr_ff;
      pin_claimed_in  = pin_claimed_ff;
      slot_claimed_in = slot_claimed_ff;
      ram_wr_en       = 1'b0;
      ram_rd_en       = accept;
      ram_rd_addr     = req_pin[PIN_W-1:0];
      emit            = 1'b0;
      emit_status     = rct_pkg::STATUS_OK;
      slot_wr         = 1'b0;

      if (chk_vld_ff && pin_claimed_ff[chk_addr_ff] && (ram_rd_data == owner_ff)) begin
         pin_claimed_in[chk_addr_ff] = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            case (func_ff)
               rct_pkg::FUNC_PIN: begin
                  if (!pin_in_range) begin
                     emit_status = rct_pkg::STATUS_INVALID;
                  end else if (pin_reserved) begin
                     emit_status = rct_pkg::STATUS_CONFLICT;
                  end else if (!pin_held) begin
                     emit_status = rct_pkg::STATUS_OK;
                  end else if (ram_rd_data == owner_ff) begin
                     emit_status = rct_pkg::STATUS_OK;
                  end else begin
                     emit_status = rct_pkg::STATUS_CONFLICT;
                  end
                  if (out_free) begin
                     emit     = 1'b1;
                     state_in = S_IDLE;
                     if (pin_in_range && !pin_reserved && !pin_held) begin
                        ram_wr_en               = 1'b1;
                        pin_claimed_in[pin_idx] = 1'b1;
                     end
                  end
               end
               rct_pkg::FUNC_BUS: begin
                  if ((key_ff == '0) || (freq_ff == '0)) begin
                     emit_status = rct_pkg::STATUS_INVALID;
                  end else if (hit_found) begin
                     if ((slot_owner_ff[hit_idx] != owner_ff)
                         && (slot_freq_ff[hit_idx] != freq_ff)) begin
                        emit_status = rct_pkg::STATUS_CONFLICT;
                     end
                  end else if (!free_found) begin
                     emit_status = rct_pkg::STATUS_NOSPACE;
                  end
                  if (out_free) begin
                     emit     = 1'b1;
                     state_in = S_IDLE;
                     if ((key_ff != '0) && (freq_ff != '0) && !hit_found && free_found) begin
                        slot_wr                   = 1'b1;
                        slot_claimed_in[free_idx] = 1'b1;
                     end
                  end
               end
               rct_pkg::FUNC_RELEASE: begin
                  slot_claimed_in = slot_claimed_ff & ~slot_own_vec;
                  cnt_in          = '0;
                  state_in        = S_SWEEP;
               end
               default: begin
                  emit_status = rct_pkg::STATUS_INVALID;
                  if (out_free) begin
                     emit     = 1'b1;
                     state_in = S_IDLE;
                  end
               end
            endcase
         end
         S_SWEEP: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = cnt_ff[PIN_W-1:0];
            chk_vld_in  = 1'b1;
            chk_addr_in = cnt_ff[PIN_W-1:0];
            cnt_in      = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(PIN_COUNT - 1)) begin
               state_in = S_SWEEP_END;
            end
         end
         S_SWEEP_END: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (out_free) begin
               emit     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in  = emit || (rsp_valid_ff && rsp_stall);
      rsp_status_in = emit ? emit_status : rsp_status_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         mask_ff         <= '0;
         cnt_ff          <= '0;
         chk_vld_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         pin_claimed_ff  <= '0;
         slot_claimed_ff <= '0;
      end else begin
         state_ff        <= state_in;
         mask_ff         <= mask_in;
         cnt_ff          <= cnt_in;
         chk_vld_ff      <= chk_vld_in;
         rsp_valid_ff    <= rsp_valid_in;
         pin_claimed_ff  <= pin_claimed_in;
         slot_claimed_ff <= slot_claimed_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_addr_ff   <= chk_addr_in;
      rsp_status_ff <= rsp_status_in;
      if (accept) begin
         func_ff  <= req_func;
         owner_ff <= req_owner_id;
         pin_ff   <= req_pin;
         key_ff   <= req_bus_key;
         freq_ff  <= req_bus_freq;
      end
      if (slot_wr) begin
         slot_key_ff[free_idx]   <= key_ff;
         slot_owner_ff[free_idx] <= owner_ff;
         slot_freq_ff[free_idx]  <= freq_ff;
      end
   end

   rct_ram #(
      .WIDTH (rct_pkg::OWNER_W),
      .DEPTH (PIN_COUNT)
   ) u_owner_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (pin_idx),
      .wr_data (owner_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;

   a_claim_on_write: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |=> pin_claimed_ff[$past(pin_idx)])
      else $error("owner written without claim flag set");

   a_sweep_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SWEEP_END) |-> (cnt_ff == CNT_W'(PIN_COUNT)))
      else $error("sweep ended before covering every pin");

   a_slots_released: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH) |-> (slot_own_vec == '0))
      else $error("bus slot still held by released owner");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the resource claim table
// Drives acquire-pin, acquire-bus, release-all and undefined requests with
// random gaps and response stalls, and rewrites the reserved pin mask between
// phases. A local ownership table predicts every response status, and the
// monitor checks each response against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int PINS          = rct_pkg::PIN_COUNT_DEF;
   localparam int SLOTS         = rct_pkg::BUS_SLOTS_DEF;
   localparam int SETTLE_CYCLES = PINS + 8;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int PHASES        = 5;
   localparam int PHASE_ITEMS   = 100;

   localparam logic [rct_pkg::FUNC_W-1:0] FUNC_UNDEF = 2'd3;

   typedef enum logic [1:0] {STEP_REQUEST, STEP_MASK, STEP_DRAIN} step_kind_type;

   typedef struct {
      step_kind_type                  kind;
      logic [rct_pkg::FUNC_W-1:0]     func;
      rct_pkg::owner_type             owner;
      logic [rct_pkg::PIN_NUM_W-1:0]  pin;
      logic [rct_pkg::KEY_W-1:0]      key;
      logic [rct_pkg::FREQ_W-1:0]     freq;
      logic [rct_pkg::MASK_W-1:0]     mask;
      int                             gap;
   } plan_step_type;

   logic                           clock        = 1'b0;
   logic                           reset        = 1'b1;
   logic                           req_valid    = 1'b0;
   logic                           req_stall;
   logic [rct_pkg::FUNC_W-1:0]     req_func     = '0;
   logic [rct_pkg::OWNER_W-1:0]    req_owner_id = '0;
   logic [rct_pkg::PIN_NUM_W-1:0]  req_pin      = '0;
   logic [rct_pkg::KEY_W-1:0]      req_bus_key  = '0;
   logic [rct_pkg::FREQ_W-1:0]     req_bus_freq = '0;
   logic                           rsp_valid;
   logic                           rsp_stall    = 1'b0;
   logic [rct_pkg::STATUS_W-1:0]   rsp_status;
   logic                           csr_wr_en    = 1'b0;
   logic [rct_pkg::MASK_W-1:0]     csr_wr_data  = '0;

   plan_step_type                  request_plan[$];
   logic [rct_pkg::STATUS_W-1:0]   pending_status[$];

   logic [rct_pkg::MASK_W-1:0]     reserved_mask;
   bit                             pin_held[PINS];
   rct_pkg::owner_type             pin_holder[PINS];
   bit                             slot_used[SLOTS];
   logic [rct_pkg::KEY_W-1:0]      slot_name[SLOTS];
   rct_pkg::owner_type             slot_holder[SLOTS];
   logic [rct_pkg::FREQ_W-1:0]     slot_rate[SLOTS];

   logic                  req_taken    = 1'b0;
   int                    quiet_cycles = 0;
   int                    gap_left     = 0;
   int                    stall_left   = 0;
   int                    calm_left    = 0;
   bit                    calm         = 1'b0;
   bit                    burst_mode   = 1'b0;
   int                    errors       = 0;
   int                    mask_writes  = 0;
   int                    func_count[4];
   int                    status_count[4];

   always #5 clock = ~clock;

   resource_claim_table_top #(
      .PIN_COUNT (PINS),
      .BUS_SLOTS (SLOTS)
   ) DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_func     (req_func),
      .req_owner_id (req_owner_id),
      .req_pin      (req_pin),
      .req_bus_key  (req_bus_key),
      .req_bus_freq (req_bus_freq),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_status   (rsp_status),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data)
   );

   function automatic logic [rct_pkg::STATUS_W-1:0] claim_outcome(
      logic [rct_pkg::FUNC_W-1:0] f, rct_pkg::owner_type who,
      logic [rct_pkg::PIN_NUM_W-1:0] p,
      logic [rct_pkg::KEY_W-1:0] k, logic [rct_pkg::FREQ_W-1:0] fr);
      int hit;
      hit = -1;
      case (f)
         rct_pkg::FUNC_PIN: begin
            if (p >= PINS) return rct_pkg::STATUS_INVALID;
            if (reserved_mask[p]) return rct_pkg::STATUS_CONFLICT;
            if (!pin_held[p]) begin
               pin_held[p]   = 1'b1;
               pin_holder[p] = who;
               return rct_pkg::STATUS_OK;
            end
            return (pin_holder[p] == who) ? rct_pkg::STATUS_OK : rct_pkg::STATUS_CONFLICT;
         end
         rct_pkg::FUNC_BUS: begin
            if (k == '0 || fr == '0) return rct_pkg::STATUS_INVALID;
            for (int i = 0; i < SLOTS && hit < 0; i++)
               if (slot_used[i] && slot_name[i] == k) hit = i;
            if (hit < 0) begin
               for (int i = 0; i < SLOTS && hit < 0; i++)
                  if (!slot_used[i]) hit = i;
               if (hit < 0) return rct_pkg::STATUS_NOSPACE;
               slot_used[hit]   = 1'b1;
               slot_name[hit]   = k;
               slot_holder[hit] = who;
               slot_rate[hit]   = fr;
               return rct_pkg::STATUS_OK;
            end
            if (slot_holder[hit] != who && slot_rate[hit] != fr)
               return rct_pkg::STATUS_CONFLICT;
            return rct_pkg::STATUS_OK;
         end
         rct_pkg::FUNC_RELEASE: begin
            for (int i = 0; i < PINS; i++)
               if (pin_held[i] && pin_holder[i] == who) begin
                  pin_held[i]   = 1'b0;
                  pin_holder[i] = '0;
               end
            for (int i = 0; i < SLOTS; i++)
               if (slot_used[i] && slot_holder[i] == who) begin
                  slot_used[i]   = 1'b0;
                  slot_name[i]   = '0;
                  slot_holder[i] = '0;
                  slot_rate[i]   = '0;
               end
            return rct_pkg::STATUS_OK;
         end
         default: return rct_pkg::STATUS_INVALID;
      endcase
   endfunction

   task automatic push_request(logic [rct_pkg::FUNC_W-1:0] f, rct_pkg::owner_type who,
      logic [rct_pkg::PIN_NUM_W-1:0] p, logic [rct_pkg::KEY_W-1:0] k,
      logic [rct_pkg::FREQ_W-1:0] fr);
      plan_step_type s;
      int            r;
      r = $urandom_range(0, 99);
      s.kind  = STEP_REQUEST;
      s.func  = f;
      s.owner = who;
      s.pin   = p;
      s.key   = k;
      s.freq  = fr;
      s.mask  = '0;
      if (burst_mode || r < 55) s.gap = 0;
      else if (r < 90) s.gap = $urandom_range(1, 3);
      else s.gap = $urandom_range(8, 30);
      request_plan.push_back(s);
   endtask

   task automatic push_control(step_kind_type kind, logic [rct_pkg::MASK_W-1:0] m);
      plan_step_type s;
      s = '{kind: kind, func: '0, owner: '0, pin: '0, key: '0, freq: '0, mask: m, gap: 0};
      request_plan.push_back(s);
   endtask

   always @(negedge clock) begin : drive_p
      plan_step_type s;
      logic          nxt_valid;
      logic          nxt_csr;
      nxt_valid = req_valid;
      nxt_csr   = 1'b0;
      if (reset) begin
         nxt_valid = 1'b0;
      end else if (!(req_valid && !req_taken)) begin
         nxt_valid = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (request_plan.size() != 0) begin
            s = request_plan[0];
            case (s.kind)
               STEP_REQUEST: begin
                  req_func     <= s.func;
                  req_owner_id <= s.owner;
                  req_pin      <= s.pin;
                  req_bus_key  <= s.key;
                  req_bus_freq <= s.freq;
                  nxt_valid = 1'b1;
                  gap_left  = s.gap;
                  void'(request_plan.pop_front());
               end
               STEP_MASK: begin
                  if (pending_status.size() == 0 && quiet_cycles >= SETTLE_CYCLES) begin
                     csr_wr_data <= s.mask;
                     nxt_csr = 1'b1;
                     void'(request_plan.pop_front());
                  end
               end
               default: begin
                  if (pending_status.size() == 0) void'(request_plan.pop_front());
               end
            endcase
         end
      end
      req_valid <= nxt_valid;
      csr_wr_en <= nxt_csr;
   end

   always @(negedge clock) begin : stall_p
      int r;
      if (calm_left > 0) begin
         calm_left--;
      end else begin
         calm      = ($urandom_range(0, 3) == 0);
         calm_left = $urandom_range(100, 400);
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         r = $urandom_range(0, 99);
         if (!calm && r < 25) stall_left = $urandom_range(1, 3);
         else if (!calm && r < 27) stall_left = $urandom_range(10, 40);
      end
   end

   always @(posedge clock) begin : check_p
      logic [rct_pkg::STATUS_W-1:0] want;
      if (reset) begin
         reserved_mask = '0;
         for (int i = 0; i < PINS; i++) begin
            pin_held[i]   = 1'b0;
            pin_holder[i] = '0;
         end
         for (int i = 0; i < SLOTS; i++) begin
            slot_used[i]   = 1'b0;
            slot_name[i]   = '0;
            slot_holder[i] = '0;
            slot_rate[i]   = '0;
         end
         req_taken <= 1'b0;
         quiet_cycles = 0;
      end else begin
         if (csr_wr_en) begin
            reserved_mask = csr_wr_data;
            mask_writes++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_status.size() == 0) begin
               $error("unexpected response: status actual %0d", rsp_status);
               errors++;
            end else begin
               want = pending_status.pop_front();
               status_count[want]++;
               if (rsp_status !== want) begin
                  $error("status mismatch: expected %0d, actual %0d", want, rsp_status);
                  errors++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            func_count[req_func]++;
            pending_status.push_back(claim_outcome(req_func, req_owner_id, req_pin,
                                                   req_bus_key, req_bus_freq));
         end
         req_taken <= req_valid && !req_stall;
         if ((req_valid && !req_stall) || pending_status.size() != 0) quiet_cycles = 0;
         else quiet_cycles++;
      end
   end

   initial begin : watchdog_p
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("tb_top failed");
      $finish;
   end

   initial begin : stimulus_p
      rct_pkg::owner_type             owner_pool[5];
      logic [rct_pkg::KEY_W-1:0]      key_pool[6];
      logic [rct_pkg::FREQ_W-1:0]     freq_pool[4];
      logic [rct_pkg::MASK_W-1:0]     m;
      logic [rct_pkg::FUNC_W-1:0]     f;
      rct_pkg::owner_type             who;
      logic [rct_pkg::PIN_NUM_W-1:0]  p;
      logic [rct_pkg::KEY_W-1:0]      k;
      logic [rct_pkg::FREQ_W-1:0]     fr;
      int                             r;

      owner_pool = '{8'h00, 8'h01, 8'h02, 8'h80, 8'hFF};
      key_pool   = '{64'h1, 64'h5350_4931, 64'h4932_4330, 64'h5541_5254,
                     64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF};
      freq_pool  = '{24'd1, 24'd100000, 24'd400000, 24'hFFFFFF};

      // directed: reserved edges, range limits, sharing, full slots, release
      push_control(STEP_MASK, 64'h8000_0000_0000_0001);
      push_request(rct_pkg::FUNC_PIN, 8'd1, 7'd0, '0, '0);
      push_request(rct_pkg::FUNC_PIN, 8'd1, 7'd63, '0, '0);
      push_request(rct_pkg::FUNC_PIN, 8'd1, 7'd64, '0, '0);
      push_request(rct_pkg::FUNC_PIN, 8'd1, 7'd127, '0, '0);
      push_request(rct_pkg::FUNC_PIN, 8'd0, 7'd1, '0, '0);
      push_request(rct_pkg::FUNC_PIN, 8'd0, 7'd1, '0, '0);
      push_request(rct_pkg::FUNC_PIN, 8'd255, 7'd1, '0, '0);
      push_request(rct_pkg::FUNC_PIN, 8'd255, 7'd62, '0, '0);
      push_request(FUNC_UNDEF, 8'd255, 7'd127, '1, '1);
      push_request(rct_pkg::FUNC_BUS, 8'd1, 7'd0, '0, 24'd100);
      push_request(rct_pkg::FUNC_BUS, 8'd1, 7'd0, 64'h77, '0);
      push_request(rct_pkg::FUNC_BUS, 8'd1, 7'd0, '1, 24'hFFFFFF);
      push_request(rct_pkg::FUNC_BUS, 8'd2, 7'd0, '1, 24'd5);
      push_request(rct_pkg::FUNC_BUS, 8'd2, 7'd0, '1, 24'hFFFFFF);
      push_request(rct_pkg::FUNC_BUS, 8'd1, 7'd0, '1, 24'd7);
      push_request(rct_pkg::FUNC_BUS, 8'd3, 7'd0, 64'd2, 24'd1);
      push_request(rct_pkg::FUNC_BUS, 8'd3, 7'd0, 64'd3, 24'd1);
      push_request(rct_pkg::FUNC_BUS, 8'd3, 7'd0, 64'd4, 24'd1);
      push_request(rct_pkg::FUNC_BUS, 8'd3, 7'd0, 64'd5, 24'd1);
      push_request(rct_pkg::FUNC_RELEASE, 8'd1, 7'd0, '0, '0);
      push_request(rct_pkg::FUNC_BUS, 8'd3, 7'd0, 64'd5, 24'd1);
      push_request(rct_pkg::FUNC_RELEASE, 8'd77, 7'd0, '0, '0);
      push_request(rct_pkg::FUNC_RELEASE, 8'd0, 7'd0, '0, '0);
      push_request(rct_pkg::FUNC_PIN, 8'd255, 7'd1, '0, '0);
      push_control(STEP_DRAIN, '0);

      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0:       m = '1;
            1:       m = {$urandom, $urandom};
            2:       m = '0;
            3:       m = {$urandom, $urandom} & {$urandom, $urandom};
            default: m = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
         endcase
         push_control(STEP_MASK, m);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 16 == 0) burst_mode = ($urandom_range(0, 2) == 0);
            if ($urandom_range(0, 99) == 0 || (ph == 2 && n == 50))
               push_control(STEP_DRAIN, '0);
            r = $urandom_range(0, 99);
            if (r < 40) f = rct_pkg::FUNC_PIN;
            else if (r < 75) f = rct_pkg::FUNC_BUS;
            else if (r < 95) f = rct_pkg::FUNC_RELEASE;
            else f = FUNC_UNDEF;
            r = $urandom_range(0, 99);
            who = (r < 85) ? owner_pool[$urandom_range(0, 4)]
                           : rct_pkg::owner_type'($urandom_range(0, 255));
            r = $urandom_range(0, 99);
            if (r < 50) p = rct_pkg::PIN_NUM_W'($urandom_range(0, 7));
            else if (r < 85) p = rct_pkg::PIN_NUM_W'($urandom_range(0, 63));
            else p = rct_pkg::PIN_NUM_W'($urandom_range(64, 127));
            r = $urandom_range(0, 99);
            if (r < 80) k = key_pool[$urandom_range(0, 5)];
            else if (r < 90) k = {$urandom, $urandom};
            else k = '0;
            r = $urandom_range(0, 99);
            if (r < 80) fr = freq_pool[$urandom_range(0, 3)];
            else if (r < 93) fr = rct_pkg::FREQ_W'($urandom_range(1, 24'hFFFFFF));
            else fr = '0;
            push_request(f, who, p, k, fr);
         end
      end

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      do @(posedge clock);
      while (request_plan.size() != 0 || pending_status.size() != 0 || req_valid);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_status.size() != 0) begin
         $error("%0d responses never arrived", pending_status.size());
         errors++;
      end

      $display("requests: %0d pin, %0d bus, %0d release, %0d undefined; %0d mask writes",
               func_count[rct_pkg::FUNC_PIN], func_count[rct_pkg::FUNC_BUS],
               func_count[rct_pkg::FUNC_RELEASE], func_count[FUNC_UNDEF], mask_writes);
      $display("statuses: %0d ok, %0d invalid, %0d conflict, %0d no space; %0d errors",
               status_count[rct_pkg::STATUS_OK], status_count[rct_pkg::STATUS_INVALID],
               status_count[rct_pkg::STATUS_CONFLICT], status_count[rct_pkg::STATUS_NOSPACE],
               errors);
      if (errors == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
